/* src/bls_pkg.sv */
// ----------------------------------------------------------------------------
// bls_pkg: shared types and constants of the long/short press detector
// Holds the configuration, item and result types, the register indexes,
// the press codes and the reset values of the registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bls_pkg;

  // Configuration port geometry.
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  // Register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_SHORTCUT_ENABLE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_RELEASE_HOLD_MS = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_LONG_PRESS_MS   = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_UP_DELAY_MS = 2'd3;

  // Register reset values.
  localparam logic        RST_SHORTCUT_ENABLE = 1'b1;
  localparam logic [9:0]  RST_RELEASE_HOLD_MS = 10'd50;
  localparam logic [15:0] RST_LONG_PRESS_MS   = 16'd750;
  localparam logic [9:0]  RST_KEY_UP_DELAY_MS = 10'd30;

  // Item kinds.
  localparam logic KIND_TICK  = 1'b0;
  localparam logic KIND_RESET = 1'b1;

  // Reports shorter than this are ignored; the button is bit 0 of the status byte.
  localparam logic [15:0] MIN_REPORT_LEN = 16'd10;
  localparam int          BUTTON_BIT     = 0;

  typedef enum logic [1:0] {
    PRESS_NONE  = 2'd0,
    PRESS_LONG  = 2'd1,
    PRESS_SHORT = 2'd2
  } press_t;

  typedef struct packed {
    logic        shortcut_enable;
    logic [9:0]  release_hold_ms;
    logic [15:0] long_press_ms;
    logic [9:0]  key_up_delay_ms;
  } cfg_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] now_ms;
    logic [7:0]  status_byte;
    logic [15:0] report_length;
    logic        host_ready;
  } item_t;

  typedef struct packed {
    logic   key_up_sent;
    press_t press_code;
  } result_t;

endpackage

`default_nettype wire

/* src/bls_cfg.sv */
// ----------------------------------------------------------------------------
// bls_cfg: configuration registers
// Four write-only registers loaded through a simple write-enable port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bls_cfg (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [bls_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [bls_pkg::CFG_DATA_W-1:0]  cfg_data,
  output bls_pkg::cfg_t                      cfg
);
  import bls_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.shortcut_enable <= RST_SHORTCUT_ENABLE;
      cfg.release_hold_ms <= RST_RELEASE_HOLD_MS;
      cfg.long_press_ms   <= RST_LONG_PRESS_MS;
      cfg.key_up_delay_ms <= RST_KEY_UP_DELAY_MS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SHORTCUT_ENABLE: cfg.shortcut_enable <= cfg_data[0];
        REG_RELEASE_HOLD_MS: cfg.release_hold_ms <= cfg_data[9:0];
        REG_LONG_PRESS_MS:   cfg.long_press_ms   <= cfg_data[15:0];
        REG_KEY_UP_DELAY_MS: cfg.key_up_delay_ms <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

/* src/bls_core.sv */
// ----------------------------------------------------------------------------
// bls_core: press detector state and single-pass step logic
// Computes the result of one item from the registered item and the detector
// state, and updates the state when the item moves on.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bls_core (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     step,
  input  wire bls_pkg::item_t item,
  input  wire bls_pkg::cfg_t  cfg,
  output bls_pkg::result_t res
);
  import bls_pkg::*;

  logic        button_held, button_held_next;
  logic [31:0] last_high_ms, last_high_ms_next;
  logic        was_held, was_held_next;
  logic [31:0] press_start_ms, press_start_ms_next;
  logic        long_fired, long_fired_next;
  logic        key_up_pending, key_up_pending_next;
  logic [31:0] key_up_due_ms, key_up_due_ms_next;

  logic [31:0] since_high;
  logic [31:0] since_due;
  logic [31:0] since_press;
  logic [31:0] due_new;
  logic        tick_used;

  assign since_high  = item.now_ms - last_high_ms;
  assign since_due   = item.now_ms - key_up_due_ms;
  assign since_press = item.now_ms - press_start_ms;
  assign due_new     = item.now_ms + {22'd0, cfg.key_up_delay_ms};
  assign tick_used   = (item.report_length >= MIN_REPORT_LEN) && cfg.shortcut_enable;

  always_comb begin
    button_held_next    = button_held;
    last_high_ms_next   = last_high_ms;
    was_held_next       = was_held;
    press_start_ms_next = press_start_ms;
    long_fired_next     = long_fired;
    key_up_pending_next = key_up_pending;
    key_up_due_ms_next  = key_up_due_ms;
    res.key_up_sent     = 1'b0;
    res.press_code      = PRESS_NONE;

    if (item.kind == KIND_RESET) begin
      res.key_up_sent     = key_up_pending && item.host_ready;
      button_held_next    = 1'b0;
      last_high_ms_next   = '0;
      was_held_next       = 1'b0;
      press_start_ms_next = '0;
      long_fired_next     = 1'b0;
      key_up_pending_next = 1'b0;
      key_up_due_ms_next  = '0;
    end else if (tick_used) begin
      // The button stays held until the bit has been low for longer than the hold time.
      if (item.status_byte[BUTTON_BIT]) begin
        button_held_next  = 1'b1;
        last_high_ms_next = item.now_ms;
      end else if (since_high > {22'd0, cfg.release_hold_ms}) begin
        button_held_next = 1'b0;
      end

      // A due key-up goes out first; the sign bit of the difference is the
      // wrap-safe "due" test.
      if (key_up_pending && !since_due[31] && item.host_ready) begin
        res.key_up_sent     = 1'b1;
        key_up_pending_next = 1'b0;
      end

      if (button_held_next && !was_held) begin
        press_start_ms_next = item.now_ms;
        was_held_next       = 1'b1;
        long_fired_next     = 1'b0;
      end else if (button_held_next && was_held) begin
        if (!long_fired && (since_press >= {16'd0, cfg.long_press_ms})
            && item.host_ready) begin
          res.press_code      = PRESS_LONG;
          long_fired_next     = 1'b1;
          key_up_pending_next = 1'b1;
          key_up_due_ms_next  = due_new;
        end
      end else if (!button_held_next && was_held) begin
        if (!long_fired && item.host_ready) begin
          res.press_code      = PRESS_SHORT;
          key_up_pending_next = 1'b1;
          key_up_due_ms_next  = due_new;
        end
        was_held_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      button_held    <= 1'b0;
      last_high_ms   <= '0;
      was_held       <= 1'b0;
      press_start_ms <= '0;
      long_fired     <= 1'b0;
      key_up_pending <= 1'b0;
      key_up_due_ms  <= '0;
    end else if (step) begin
      button_held    <= button_held_next;
      last_high_ms   <= last_high_ms_next;
      was_held       <= was_held_next;
      press_start_ms <= press_start_ms_next;
      long_fired     <= long_fired_next;
      key_up_pending <= key_up_pending_next;
      key_up_due_ms  <= key_up_due_ms_next;
    end
  end

`ifndef SYNTH
  // Every press schedules a key-up.
  a_press_schedules_key_up: assert property (@(posedge clk) disable iff (rst)
    step && (res.press_code != PRESS_NONE) |=> key_up_pending)
    else $error("press did not leave a key-up pending");

  // Nothing is reported to a busy host.
  a_report_needs_host: assert property (@(posedge clk) disable iff (rst)
    step && (res.key_up_sent || (res.press_code != PRESS_NONE)) |-> item.host_ready)
    else $error("report produced while the host was busy");

  // A reset item clears the detector.
  a_reset_clears: assert property (@(posedge clk) disable iff (rst)
    step && (item.kind == KIND_RESET) |=> !key_up_pending && !was_held && !button_held)
    else $error("reset item left state behind");

  // A long press fires only once per hold.
  a_long_once: assert property (@(posedge clk) disable iff (rst)
    step && long_fired && was_held && button_held_next |-> res.press_code != PRESS_LONG)
    else $error("long press fired twice");
`endif

endmodule

`default_nettype wire

/* src/button_long_short_press_shortcut.sv */
// ----------------------------------------------------------------------------
// button_long_short_press_shortcut: long/short press shortcut detector
// Turns controller report ticks into modifier+tab (long) and modifier+g
// (short) press reports with a delayed key-up.
// ----------------------------------------------------------------------------
// The block takes one transaction per clock cycle on the input channel while
// the output side is not stalled, and returns exactly one result transaction
// for each, in order. An accepted item waits in the input register, and one
// pass through the step logic loads its result into the result register,
// which drives the output channel. The rate is set by that single pass of
// 32-bit subtracts, compares and one add between the two registers. When the
// output side stalls, the input register holds its item; once both registers
// are full, in_ready follows out_ready.
// Configuration registers are written through cfg_we, cfg_index and cfg_data
// and should only be changed while no transaction is in flight.
`timescale 1ns / 1ps
`default_nettype none

module button_long_short_press_shortcut (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // Configuration write port.
  input  wire logic                            cfg_we,
  input  wire logic [bls_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [bls_pkg::CFG_DATA_W-1:0]  cfg_data,
  // Input channel.
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic                            kind,
  input  wire logic [31:0]                     now_ms,
  input  wire logic [7:0]                      status_byte,
  input  wire logic [15:0]                     report_length,
  input  wire logic                            host_ready,
  // Output channel.
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic                                 key_up_sent,
  output logic [1:0]                           press_code
);
  import bls_pkg::*;

  cfg_t    cfg;
  item_t   item_q;
  logic    stage_valid;
  result_t core_res;
  result_t res_q;
  logic    advance;
  logic    step;

  // The result register can take a new value when it is empty or is being
  // drained this cycle; the input register then moves into it.
  assign advance  = !out_valid || out_ready;
  assign in_ready = !stage_valid || advance;
  assign step     = stage_valid && advance;

  bls_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      stage_valid <= 1'b1;
    end else if (advance) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_q.kind          <= kind;
      item_q.now_ms        <= now_ms;
      item_q.status_byte   <= status_byte;
      item_q.report_length <= report_length;
      item_q.host_ready    <= host_ready;
    end
  end

  // Step logic and detector state.
  bls_core u_core (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .item (item_q),
    .cfg  (cfg),
    .res  (core_res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_q <= core_res;
    end
  end

  assign key_up_sent = res_q.key_up_sent;
  assign press_code  = res_q.press_code;

endmodule

`default_nettype wire
